FILE: sv/sdm_pkg.sv
// Package for the stack with middle removal: beat types, codes, sizing.
// Used by stack_delete_middle; no dependencies.
package sdm_pkg;

  // stack sizing
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  // request codes
  localparam logic REQ_PUSH   = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      op_status;
    logic                     entry_valid;
    logic signed [DATA_W-1:0] entry_value;
    logic [POS_W-1:0]         entry_position;
    logic [COUNT_W-1:0]       entry_count;
    logic                     run_last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_t;

endpackage

FILE: sv/stack_delete_middle.sv
// An accepted request passes through ST_READ and ST_LOAD, and the first result beat
// is offered in ST_SEND; each further beat is loaded in ST_LOAD and offered in ST_SEND,
// which holds while the receiver stalls. A removal first moves floor(n/2) entries
// down, each read in ST_SHIFT_RD and written in ST_SHIFT_WR, before the readout.
// One item at a time: a new request is accepted only in ST_IDLE, after the final beat
// of the previous readout; the stack memory has a single read port.
// Reset (rst, synchronous): stack empty, sequencer idle; memory contents are not cleared.
// Depends on sdm_pkg.
module stack_delete_middle (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdm_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sdm_pkg::rsp_t out_data
);
  import sdm_pkg::*;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    k;
  logic [STATUS_W-1:0] status;
  rsp_t                out_q;

  logic signed [DATA_W-1:0] mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] rdata;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  logic signed [DATA_W-1:0] mem_wd;
  logic [ADDR_W-1:0]        mem_ra;

  logic             in_fire;
  logic             out_fire;
  logic             is_full;
  logic             too_few;
  logic [CNT_W-1:0] mid_idx;
  logic             shift_more;
  logic             last_beat;

  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign is_full    = (count == CNT_W'(STACK_DEPTH));
  assign too_few    = (count < CNT_W'(2));
  // position floor(n/2) from the top, as an index from the bottom
  assign mid_idx    = count - CNT_W'(1) - (count >> 1);
  assign shift_more = ({1'b0, ptr} + (CNT_W+1)'(2)) < {1'b0, count};
  assign last_beat  = out_q.run_last;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.req_type == REQ_REMOVE && !too_few) begin
            state_next = ST_SHIFT_RD;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: state_next = shift_more ? ST_SHIFT_RD : ST_READ;
      ST_READ:     state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_SEND;
      ST_SEND: begin
        if (out_fire) begin
          state_next = last_beat ? ST_IDLE : ST_LOAD;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // handshake and memory port control
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = ptr[ADDR_W-1:0];
    mem_wd    = rdata;
    mem_ra    = ADDR_W'(count - CNT_W'(1) - k);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_data.req_type == REQ_PUSH && !is_full) begin
          mem_we = 1'b1;
          mem_wa = count[ADDR_W-1:0];
          mem_wd = in_data.push_value;
        end
      end
      ST_SHIFT_RD: mem_ra = ADDR_W'(ptr + CNT_W'(1));
      ST_SHIFT_WR: mem_we = 1'b1;
      ST_READ:     mem_ra = ADDR_W'(count - CNT_W'(1) - k);
      ST_LOAD:     mem_ra = ADDR_W'(count - CNT_W'(1) - k);
      ST_SEND: begin
        out_valid = 1'b1;
        // prefetch the next entry down while this beat goes out
        mem_ra    = ADDR_W'(count - CNT_W'(2) - k);
      end
      default: ;
    endcase
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_fire && in_data.req_type == REQ_PUSH && !is_full) begin
        count <= count + CNT_W'(1);
      end else if (state == ST_SHIFT_WR && !shift_more) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // sequencer datapath: status, shift pointer, readout position, result beat
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        k <= '0;
        if (in_fire) begin
          ptr <= mid_idx;
          if (in_data.req_type == REQ_PUSH && is_full) begin
            status <= STATUS_FULL;
          end else if (in_data.req_type == REQ_REMOVE && too_few) begin
            status <= STATUS_UNDER;
          end else begin
            status <= STATUS_DONE;
          end
        end
      end
      ST_SHIFT_WR: ptr <= ptr + CNT_W'(1);
      ST_LOAD: begin
        out_q.op_status      <= status;
        out_q.entry_position <= POS_W'(k);
        out_q.entry_count    <= COUNT_W'(count);
        if (count == '0) begin
          out_q.entry_valid <= 1'b0;
          out_q.entry_value <= '0;
          out_q.run_last    <= 1'b1;
        end else begin
          out_q.entry_valid <= 1'b1;
          out_q.entry_value <= rdata;
          out_q.run_last    <= (k + CNT_W'(1) == count);
        end
      end
      ST_SEND: begin
        if (out_fire && !last_beat) begin
          k <= k + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_data = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("fill count beyond stack depth");

  a_sides_apart: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result beat is offered");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.run_last |=> in_ready)
    else $error("sequencer not idle after final beat");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count == COUNT_W'(count))
    else $error("beat count differs from fill count");

endmodule
